[rtl/skvt_pkg.sv]
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared types and codes for the sorted key/value table: command and status
// codes, and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package skvt_pkg;

	localparam int DEPTH_DEF    = 16;
	localparam int AMP_BITS_DEF = 16;
	localparam int KEY_W        = 8;
	localparam int AMP_IO_W     = 16;

	typedef logic [1:0] cmd_code_t;
	typedef logic [1:0] status_t;

	localparam cmd_code_t CMD_ADD    = 2'd0;
	localparam cmd_code_t CMD_UPDATE = 2'd1;
	localparam cmd_code_t CMD_REMOVE = 2'd2;
	localparam cmd_code_t CMD_LOOKUP = 2'd3;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_INVALID   = 2'd1;
	localparam status_t ST_NOT_FOUND = 2'd2;
	localparam status_t ST_FULL      = 2'd3;

	typedef struct packed {
		logic    load;
		logic    rd_idx;
		logic    rd_dn;
		logic    rd_up;
		logic    idx_inc;
		logic    set_found;
		logic    wr_pos;
		logic    wr_sh;
		logic    sh_load_count;
		logic    sh_load_idx;
		logic    sh_dec;
		logic    sh_inc;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    finish;
		status_t fin_status;
		logic    fin_amp;
	} dp_cmd_t;

	typedef struct packed {
		cmd_code_t cmd;
		logic      key_zero;
		logic      scan_end;
		logic      hit;
		logic      found;
		logic      full;
		logic      ins_done;
		logic      rem_done;
	} dp_sts_t;

endpackage

[rtl/skvt_dp.sv]
// ----------------------------------------------------------------------------
// skvt_dp
// Datapath: key and amplitude memories, request registers, scan and shift
// indexes, entry count and the result register.
// ----------------------------------------------------------------------------
module skvt_dp #(
	parameter int DEPTH    = skvt_pkg::DEPTH_DEF,
	parameter int AMP_BITS = skvt_pkg::AMP_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  skvt_pkg::cmd_code_t               command,
	input  logic [skvt_pkg::KEY_W-1:0]        number,
	input  logic [skvt_pkg::AMP_IO_W-1:0]     amplitude,
	input  skvt_pkg::dp_cmd_t                 dp_cmd,
	output skvt_pkg::dp_sts_t                 dp_sts,
	output skvt_pkg::status_t                 status,
	output logic [skvt_pkg::AMP_IO_W-1:0]     read_amplitude,
	output logic [$clog2(DEPTH+1)-1:0]        entry_count
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);

	logic [skvt_pkg::KEY_W-1:0] key_mem [DEPTH];
	logic [AMP_BITS-1:0]        amp_mem [DEPTH];

	skvt_pkg::cmd_code_t        cmd_q;
	logic [skvt_pkg::KEY_W-1:0] key_q;
	logic [AMP_BITS-1:0]        amp_q;
	logic [CW-1:0]              count_q;
	logic [CW-1:0]              count_d;
	logic [CW-1:0]              idx_q;
	logic [CW-1:0]              sh_q;
	logic [CW-1:0]              sh_dn;
	logic [CW-1:0]              sh_up;
	logic                       found_q;
	logic [skvt_pkg::KEY_W-1:0] key_rd_q;
	logic [AMP_BITS-1:0]        amp_rd_q;
	logic                       rd_en;
	logic [AW-1:0]              rd_addr;
	logic                       wr_en;
	logic [AW-1:0]              wr_addr;
	logic [skvt_pkg::KEY_W-1:0] wr_key;
	logic [AMP_BITS-1:0]        wr_amp;
	skvt_pkg::status_t          status_q;
	logic [skvt_pkg::AMP_IO_W-1:0] rd_amp_q;
	logic [CW-1:0]              entry_count_q;

	assign sh_dn = sh_q - CW'(1);
	assign sh_up = sh_q + CW'(1);

	always_comb begin
		rd_en   = dp_cmd.rd_idx | dp_cmd.rd_dn | dp_cmd.rd_up;
		rd_addr = idx_q[AW-1:0];
		if (dp_cmd.rd_dn) begin
			rd_addr = sh_dn[AW-1:0];
		end else if (dp_cmd.rd_up) begin
			rd_addr = sh_up[AW-1:0];
		end
	end

	always_comb begin
		wr_en   = dp_cmd.wr_pos | dp_cmd.wr_sh;
		wr_addr = idx_q[AW-1:0];
		wr_key  = key_q;
		wr_amp  = amp_q;
		if (dp_cmd.wr_sh) begin
			wr_addr = sh_q[AW-1:0];
			wr_key  = key_rd_q;
			wr_amp  = amp_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			amp_mem[wr_addr] <= wr_amp;
		end
		if (rd_en) begin
			key_rd_q <= key_mem[rd_addr];
			amp_rd_q <= amp_mem[rd_addr];
		end
	end

	always_comb begin
		count_d = count_q;
		if (dp_cmd.cnt_inc) begin
			count_d = count_q + CW'(1);
		end else if (dp_cmd.cnt_dec) begin
			count_d = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			found_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (dp_cmd.load) begin
				found_q <= 1'b0;
			end else if (dp_cmd.set_found) begin
				found_q <= (key_rd_q == key_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			cmd_q <= command;
			key_q <= number;
			amp_q <= AMP_BITS'(amplitude);
			idx_q <= '0;
		end else if (dp_cmd.idx_inc) begin
			idx_q <= idx_q + CW'(1);
		end
		if (dp_cmd.sh_load_count) begin
			sh_q <= count_q;
		end else if (dp_cmd.sh_load_idx) begin
			sh_q <= idx_q;
		end else if (dp_cmd.sh_dec) begin
			sh_q <= sh_dn;
		end else if (dp_cmd.sh_inc) begin
			sh_q <= sh_up;
		end
		if (dp_cmd.finish) begin
			status_q      <= dp_cmd.fin_status;
			rd_amp_q      <= dp_cmd.fin_amp ? skvt_pkg::AMP_IO_W'(amp_rd_q) : '0;
			entry_count_q <= count_d;
		end
	end

	assign dp_sts.cmd      = cmd_q;
	assign dp_sts.key_zero = (key_q == '0);
	assign dp_sts.scan_end = (idx_q == count_q);
	assign dp_sts.hit      = (key_rd_q >= key_q);
	assign dp_sts.found    = found_q;
	assign dp_sts.full     = (count_q == CW'(DEPTH));
	assign dp_sts.ins_done = (sh_q == idx_q);
	assign dp_sts.rem_done = (sh_up == count_q);

	assign status         = status_q;
	assign read_amplitude = rd_amp_q;
	assign entry_count    = entry_count_q;

endmodule

[rtl/skvt_ctrl.sv]
// ----------------------------------------------------------------------------
// skvt_ctrl
// Controller: request handshake, scan, insert and remove sequencing, and the
// result valid flag.
// ----------------------------------------------------------------------------
module skvt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  skvt_pkg::dp_sts_t dp_sts,
	output skvt_pkg::dp_cmd_t dp_cmd
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_SCAN_RD  = 4'd1;
	localparam logic [3:0] S_SCAN_CMP = 4'd2;
	localparam logic [3:0] S_DECIDE   = 4'd3;
	localparam logic [3:0] S_INS_RD   = 4'd4;
	localparam logic [3:0] S_INS_WR   = 4'd5;
	localparam logic [3:0] S_REM_RD   = 4'd6;
	localparam logic [3:0] S_REM_WR   = 4'd7;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;

	assign in_stall  = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign out_valid = out_valid_q;

	always_comb begin
		dp_cmd  = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && !in_stall) begin
					dp_cmd.load = 1'b1;
					state_d     = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				if (dp_sts.key_zero) begin
					dp_cmd.finish     = 1'b1;
					dp_cmd.fin_status = skvt_pkg::ST_INVALID;
					state_d           = S_IDLE;
				end else if (dp_sts.scan_end) begin
					state_d = S_DECIDE;
				end else begin
					dp_cmd.rd_idx = 1'b1;
					state_d       = S_SCAN_CMP;
				end
			end
			S_SCAN_CMP: begin
				if (dp_sts.hit) begin
					dp_cmd.set_found = 1'b1;
					state_d          = S_DECIDE;
				end else begin
					dp_cmd.idx_inc = 1'b1;
					state_d        = S_SCAN_RD;
				end
			end
			S_DECIDE: begin
				state_d = S_IDLE;
				if (!dp_sts.found) begin
					if (dp_sts.cmd != skvt_pkg::CMD_ADD) begin
						dp_cmd.finish     = 1'b1;
						dp_cmd.fin_status = skvt_pkg::ST_NOT_FOUND;
					end else if (dp_sts.full) begin
						dp_cmd.finish     = 1'b1;
						dp_cmd.fin_status = skvt_pkg::ST_FULL;
					end else begin
						dp_cmd.sh_load_count = 1'b1;
						state_d              = S_INS_RD;
					end
				end else begin
					case (dp_sts.cmd)
						skvt_pkg::CMD_REMOVE: begin
							dp_cmd.sh_load_idx = 1'b1;
							state_d            = S_REM_RD;
						end
						skvt_pkg::CMD_LOOKUP: begin
							dp_cmd.finish     = 1'b1;
							dp_cmd.fin_status = skvt_pkg::ST_OK;
							dp_cmd.fin_amp    = 1'b1;
						end
						default: begin
							dp_cmd.wr_pos     = 1'b1;
							dp_cmd.finish     = 1'b1;
							dp_cmd.fin_status = skvt_pkg::ST_OK;
						end
					endcase
				end
			end
			S_INS_RD: begin
				if (dp_sts.ins_done) begin
					dp_cmd.wr_pos     = 1'b1;
					dp_cmd.cnt_inc    = 1'b1;
					dp_cmd.finish     = 1'b1;
					dp_cmd.fin_status = skvt_pkg::ST_OK;
					state_d           = S_IDLE;
				end else begin
					dp_cmd.rd_dn = 1'b1;
					state_d      = S_INS_WR;
				end
			end
			S_INS_WR: begin
				dp_cmd.wr_sh  = 1'b1;
				dp_cmd.sh_dec = 1'b1;
				state_d       = S_INS_RD;
			end
			S_REM_RD: begin
				if (dp_sts.rem_done) begin
					dp_cmd.cnt_dec    = 1'b1;
					dp_cmd.finish     = 1'b1;
					dp_cmd.fin_status = skvt_pkg::ST_OK;
					state_d           = S_IDLE;
				end else begin
					dp_cmd.rd_up = 1'b1;
					state_d      = S_REM_WR;
				end
			end
			S_REM_WR: begin
				dp_cmd.wr_sh  = 1'b1;
				dp_cmd.sh_inc = 1'b1;
				state_d       = S_REM_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (dp_cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/sorted_key_value_table.sv]
// ----------------------------------------------------------------------------
// sorted_key_value_table
// Sorted table of (number, amplitude) entries with add, update, remove and
// look-up requests, one result per request.
// ----------------------------------------------------------------------------
// One request at a time. The key memory has a single read port and is scanned
// linearly, one entry at a time (read, then compare), until the first key not
// below the request number; an insert or remove then moves each entry it
// shifts with a read and then a write back one place over. A new request is
// taken as soon as the previous result is in the output register and that
// register is free or being drained. The table starts empty after reset; no
// clearing pass.
module sorted_key_value_table #(
	parameter int DEPTH    = skvt_pkg::DEPTH_DEF,
	parameter int AMP_BITS = skvt_pkg::AMP_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        command,
	input  logic [skvt_pkg::KEY_W-1:0]        number,
	input  logic [skvt_pkg::AMP_IO_W-1:0]     amplitude,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        status,
	output logic [skvt_pkg::AMP_IO_W-1:0]     read_amplitude,
	output logic [$clog2(DEPTH+1)-1:0]        entry_count
);

	skvt_pkg::dp_cmd_t dp_cmd;
	skvt_pkg::dp_sts_t dp_sts;

	skvt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dp_sts    (dp_sts),
		.dp_cmd    (dp_cmd)
	);

	skvt_dp #(
		.DEPTH    (DEPTH),
		.AMP_BITS (AMP_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.command        (command),
		.number         (number),
		.amplitude      (amplitude),
		.dp_cmd         (dp_cmd),
		.dp_sts         (dp_sts),
		.status         (status),
		.read_amplitude (read_amplitude),
		.entry_count    (entry_count)
	);

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted key/value table. Requests are driven with
// random gaps and the results are drained with random stalls. A tracker keeps
// its own sorted copy of the table, predicts status, read amplitude and entry
// count for each accepted request, and compares each result with the oldest
// prediction. A directed pass covers the edge cases; biased random phases then
// fill and drain the table to reach both the empty and the full table.
// ----------------------------------------------------------------------------
module tb;
	import skvt_pkg::*;

	localparam int SLOTS       = DEPTH_DEF;
	localparam int CNT_W       = $clog2(SLOTS + 1);
	localparam int RANDOM_REQS = 2000;
	localparam int QUIET_REQS  = 300;
	localparam int IDLE_LIMIT  = 4000;
	localparam int DRAIN_WAIT  = 100;

	typedef struct packed {
		status_t             status;
		logic [AMP_IO_W-1:0] amp;
		logic [CNT_W-1:0]    count;
	} table_reply_t;

	class harmonic_table_tracker;
		logic [KEY_W-1:0]    keys[SLOTS];
		logic [AMP_IO_W-1:0] amps[SLOTS];
		int                  used;
		table_reply_t        pending_replies[$];
		int                  mismatches;

		function new();
			used       = 0;
			mismatches = 0;
		endfunction

		function int locate(logic [KEY_W-1:0] num);
			for (int i = 0; i < used; i++)
				if (keys[i] == num)
					return i;
			return used;
		endfunction

		function logic [KEY_W-1:0] stored_key();
			return keys[$urandom_range(0, used - 1)];
		endfunction

		function void apply_request(cmd_code_t cmd, logic [KEY_W-1:0] num,
				logic [AMP_IO_W-1:0] amp);
			table_reply_t r;
			int pos;
			r.status = ST_OK;
			r.amp    = '0;
			if (num == '0) begin
				r.status = ST_INVALID;
			end else begin
				pos = locate(num);
				if (cmd == CMD_ADD) begin
					if (pos < used) begin
						amps[pos] = amp;
					end else if (used >= SLOTS) begin
						r.status = ST_FULL;
					end else begin
						pos = 0;
						while (pos < used && keys[pos] < num)
							pos++;
						for (int i = used; i > pos; i--) begin
							keys[i] = keys[i - 1];
							amps[i] = amps[i - 1];
						end
						keys[pos] = num;
						amps[pos] = amp;
						used++;
					end
				end else if (pos >= used) begin
					r.status = ST_NOT_FOUND;
				end else if (cmd == CMD_UPDATE) begin
					amps[pos] = amp;
				end else if (cmd == CMD_REMOVE) begin
					for (int i = pos; i + 1 < used; i++) begin
						keys[i] = keys[i + 1];
						amps[i] = amps[i + 1];
					end
					used--;
				end else begin
					r.amp = amps[pos];
				end
			end
			r.count = used[CNT_W-1:0];
			pending_replies.push_back(r);
		endfunction

		task report_mismatch(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			mismatches++;
		endtask

		task match_reply(status_t st, logic [AMP_IO_W-1:0] amp, logic [CNT_W-1:0] cnt);
			table_reply_t e;
			if (pending_replies.size() == 0) begin
				report_mismatch("result with no request pending");
			end else begin
				e = pending_replies.pop_front();
				if (st !== e.status)
					report_mismatch($sformatf("status %0d, want %0d", st, e.status));
				if (amp !== e.amp)
					report_mismatch($sformatf("read_amplitude %h, want %h", amp, e.amp));
				if (cnt !== e.count)
					report_mismatch($sformatf("entry_count %0d, want %0d", cnt, e.count));
			end
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [1:0]          command;
	logic [KEY_W-1:0]    number;
	logic [AMP_IO_W-1:0] amplitude;
	logic                out_valid;
	logic                out_stall;
	logic [1:0]          status;
	logic [AMP_IO_W-1:0] read_amplitude;
	logic [CNT_W-1:0]    entry_count;

	harmonic_table_tracker tracker;
	bit quiet;
	int idle_cycles;

	sorted_key_value_table dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.number         (number),
		.amplitude      (amplitude),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.read_amplitude (read_amplitude),
		.entry_count    (entry_count)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			tracker.match_reply(status, read_amplitude, entry_count);
	end

	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("[sorted_key_value_table] ERROR");
		$finish;
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet && arst_n && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task send_request(cmd_code_t cmd, logic [KEY_W-1:0] num, logic [AMP_IO_W-1:0] amp);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_valid  <= 1'b1;
		command   <= cmd;
		number    <= num;
		amplitude <= amp;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		tracker.apply_request(cmd, num, amp);
		@(negedge clk);
	endtask

	task send_random_request(int add_w, int upd_w, int rem_w);
		int roll;
		cmd_code_t cmd;
		logic [KEY_W-1:0] num;
		logic [AMP_IO_W-1:0] amp;
		roll = $urandom_range(0, 99);
		if (roll < add_w)
			cmd = CMD_ADD;
		else if (roll < add_w + upd_w)
			cmd = CMD_UPDATE;
		else if (roll < add_w + upd_w + rem_w)
			cmd = CMD_REMOVE;
		else
			cmd = CMD_LOOKUP;
		roll = $urandom_range(0, 99);
		if (roll < 4)
			num = '0;
		else if (roll < 24)
			num = KEY_W'($urandom_range(1, 255));
		else if (roll < 60 && cmd != CMD_ADD && tracker.used > 0)
			num = tracker.stored_key();
		else
			num = KEY_W'($urandom_range(1, 20));
		roll = $urandom_range(0, 9);
		if (roll == 0)
			amp = '0;
		else if (roll == 1)
			amp = '1;
		else
			amp = AMP_IO_W'($urandom_range(0, 16'hFFFF));
		send_request(cmd, num, amp);
	endtask

	initial begin
		int mode;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		command   = CMD_ADD;
		number    = '0;
		amplitude = '0;
		quiet     = 1'b0;
		tracker   = new();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		send_request(CMD_LOOKUP, 8'd5, 16'h0000);
		send_request(CMD_REMOVE, 8'd5, 16'h0000);
		send_request(CMD_UPDATE, 8'd5, 16'hFFFF);
		send_request(CMD_ADD, 8'd0, 16'hFFFF);
		send_request(CMD_UPDATE, 8'd0, 16'hFFFF);
		send_request(CMD_REMOVE, 8'd0, 16'h0000);
		send_request(CMD_LOOKUP, 8'd0, 16'h0000);
		send_request(CMD_ADD, 8'd128, 16'h1234);
		send_request(CMD_ADD, 8'd255, 16'hFFFF);
		send_request(CMD_ADD, 8'd1, 16'h0000);
		send_request(CMD_ADD, 8'd64, 16'hAAAA);
		send_request(CMD_ADD, 8'd128, 16'h5555);
		send_request(CMD_UPDATE, 8'd255, 16'h8000);
		send_request(CMD_LOOKUP, 8'd128, 16'h0000);
		send_request(CMD_LOOKUP, 8'd255, 16'h0000);
		send_request(CMD_LOOKUP, 8'd1, 16'hFFFF);
		send_request(CMD_LOOKUP, 8'd64, 16'h0000);
		send_request(CMD_REMOVE, 8'd1, 16'h0000);
		send_request(CMD_REMOVE, 8'd255, 16'h0000);
		send_request(CMD_LOOKUP, 8'd255, 16'h0000);
		send_request(CMD_REMOVE, 8'd64, 16'h0000);
		send_request(CMD_REMOVE, 8'd128, 16'h0000);

		mode = 0;
		for (int n = 0; n < RANDOM_REQS; n++) begin
			if (n % 64 == 0)
				mode = (n == 0) ? 0 : $urandom_range(0, 2);
			if (n == RANDOM_REQS - QUIET_REQS)
				quiet = 1'b1;
			case (mode)
				0: send_random_request(75, 10, 5);
				1: send_random_request(15, 10, 55);
				default: send_random_request(35, 20, 20);
			endcase
		end
		in_valid <= 1'b0;

		while (tracker.pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("[sorted_key_value_table] OK");
		else
			$display("[sorted_key_value_table] ERROR");
		$finish;
	end
endmodule
